// ===== hdl/jss_pkg.sv =====
// ----------------------------------------------------------------------------
// jss_pkg
// Types, microcode word layout and program entry points of the JTAG scan
// sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package jss_pkg;

  localparam int unsigned DataW = 56;
  localparam int unsigned CntW  = 6;
  localparam int unsigned PcW   = 5;

  typedef enum logic [1:0] {
    REQ_RESET = 2'd0,
    REQ_IR    = 2'd1,
    REQ_DR    = 2'd2,
    REQ_NONE  = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    SEQ_NEXT = 2'd0,
    SEQ_LOOP = 2'd1,
    SEQ_JZ   = 2'd2,
    SEQ_END  = 2'd3
  } seq_e;

  typedef enum logic [1:0] {
    TMS_LOW   = 2'd0,
    TMS_SET   = 2'd1,
    TMS_NIDLE = 2'd2
  } tms_e;

  typedef enum logic [1:0] {
    TDI_LEVEL = 2'd0,
    TDI_DATA  = 2'd1,
    TDI_ZERO  = 2'd2
  } tdi_e;

  typedef struct packed {
    logic           emit;
    logic           tck;
    tms_e           tms_sel;
    tdi_e           tdi_sel;
    logic           wr_level;
    logic           cap_out;
    seq_e           seq;
    logic [PcW-1:0] target;
  } uword_t;

  typedef struct packed {
    logic cnt_zero;
    logic cnt_gt1;
  } dp_status_t;

  localparam logic [PcW-1:0] AddrReset = 5'd0;
  localparam logic [PcW-1:0] AddrIr    = 5'd6;
  localparam logic [PcW-1:0] AddrDr    = 5'd13;
  localparam logic [PcW-1:0] AddrDrNil = 5'd20;
  localparam logic [PcW-1:0] AddrLast  = 5'd20;

  function automatic uword_t uw(logic emit, logic tck, tms_e tms_sel, tdi_e tdi_sel,
                                logic wr_level, logic cap_out, seq_e seq,
                                logic [PcW-1:0] target);
    uword_t w;
    w.emit     = emit;
    w.tck      = tck;
    w.tms_sel  = tms_sel;
    w.tdi_sel  = tdi_sel;
    w.wr_level = wr_level;
    w.cap_out  = cap_out;
    w.seq      = seq;
    w.target   = target;
    return w;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/jss_ucode_rom.sv =====
// ----------------------------------------------------------------------------
// jss_ucode_rom
// Control store: one control word per step of the reset, IR and DR programs.
// ----------------------------------------------------------------------------
`default_nettype none

module jss_ucode_rom (
  input  wire logic [jss_pkg::PcW-1:0] pc_i,
  output jss_pkg::uword_t              uword_o
);

  always_comb begin
    unique case (pc_i)
      // tap reset: five tms-high pulses, one tms-low, tdi forced low
      5'd0, 5'd1, 5'd2, 5'd3, 5'd4: begin
        uword_o = jss_pkg::uw(1'b1, 1'b1, jss_pkg::TMS_SET, jss_pkg::TDI_ZERO,
                              1'b1, 1'b0, jss_pkg::SEQ_NEXT, '0);
      end
      5'd5: begin
        uword_o = jss_pkg::uw(1'b1, 1'b1, jss_pkg::TMS_LOW, jss_pkg::TDI_ZERO,
                              1'b1, 1'b0, jss_pkg::SEQ_END, '0);
      end
      // ir shift
      5'd6, 5'd7: begin
        uword_o = jss_pkg::uw(1'b1, 1'b1, jss_pkg::TMS_SET, jss_pkg::TDI_LEVEL,
                              1'b0, 1'b0, jss_pkg::SEQ_NEXT, '0);
      end
      5'd8: begin
        uword_o = jss_pkg::uw(1'b1, 1'b1, jss_pkg::TMS_LOW, jss_pkg::TDI_LEVEL,
                              1'b0, 1'b0, jss_pkg::SEQ_NEXT, '0);
      end
      5'd9: begin
        uword_o = jss_pkg::uw(1'b1, 1'b1, jss_pkg::TMS_LOW, jss_pkg::TDI_DATA,
                              1'b0, 1'b0, jss_pkg::SEQ_LOOP, '0);
      end
      5'd10: begin
        uword_o = jss_pkg::uw(1'b1, 1'b1, jss_pkg::TMS_SET, jss_pkg::TDI_DATA,
                              1'b1, 1'b0, jss_pkg::SEQ_NEXT, '0);
      end
      5'd11: begin
        uword_o = jss_pkg::uw(1'b1, 1'b1, jss_pkg::TMS_SET, jss_pkg::TDI_LEVEL,
                              1'b0, 1'b0, jss_pkg::SEQ_NEXT, '0);
      end
      5'd12: begin
        uword_o = jss_pkg::uw(1'b1, 1'b1, jss_pkg::TMS_SET, jss_pkg::TDI_LEVEL,
                              1'b0, 1'b0, jss_pkg::SEQ_END, '0);
      end
      // dr transfer, zero count branches off to a single non-pulse result
      5'd13: begin
        uword_o = jss_pkg::uw(1'b0, 1'b0, jss_pkg::TMS_LOW, jss_pkg::TDI_LEVEL,
                              1'b0, 1'b0, jss_pkg::SEQ_JZ, jss_pkg::AddrDrNil);
      end
      5'd14, 5'd15: begin
        uword_o = jss_pkg::uw(1'b1, 1'b1, jss_pkg::TMS_LOW, jss_pkg::TDI_LEVEL,
                              1'b0, 1'b0, jss_pkg::SEQ_NEXT, '0);
      end
      5'd16: begin
        uword_o = jss_pkg::uw(1'b1, 1'b1, jss_pkg::TMS_LOW, jss_pkg::TDI_DATA,
                              1'b0, 1'b0, jss_pkg::SEQ_LOOP, '0);
      end
      5'd17: begin
        uword_o = jss_pkg::uw(1'b1, 1'b1, jss_pkg::TMS_SET, jss_pkg::TDI_DATA,
                              1'b1, 1'b0, jss_pkg::SEQ_NEXT, '0);
      end
      5'd18: begin
        uword_o = jss_pkg::uw(1'b1, 1'b1, jss_pkg::TMS_SET, jss_pkg::TDI_LEVEL,
                              1'b0, 1'b0, jss_pkg::SEQ_NEXT, '0);
      end
      5'd19: begin
        uword_o = jss_pkg::uw(1'b1, 1'b1, jss_pkg::TMS_NIDLE, jss_pkg::TDI_LEVEL,
                              1'b0, 1'b1, jss_pkg::SEQ_END, '0);
      end
      5'd20: begin
        uword_o = jss_pkg::uw(1'b1, 1'b0, jss_pkg::TMS_LOW, jss_pkg::TDI_LEVEL,
                              1'b0, 1'b0, jss_pkg::SEQ_END, '0);
      end
      default: begin
        uword_o = jss_pkg::uw(1'b0, 1'b0, jss_pkg::TMS_LOW, jss_pkg::TDI_LEVEL,
                              1'b0, 1'b0, jss_pkg::SEQ_END, '0);
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== hdl/jss_datapath.sv =====
// ----------------------------------------------------------------------------
// jss_datapath
// Bit counter, tdi shift register, stored tdi level and captured tdo word,
// driven by the current control word.
// ----------------------------------------------------------------------------
`default_nettype none

module jss_datapath #(
  parameter int unsigned MAX_SCAN_BITS = 56
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          load_i,
  input  wire logic [1:0]                    req_type_i,
  input  wire logic [jss_pkg::CntW-1:0]      bit_count_i,
  input  wire logic [jss_pkg::DataW-1:0]     scan_data_i,
  input  wire logic [jss_pkg::DataW-1:0]     tdo_pattern_i,
  input  wire logic                          end_in_idle_i,
  input  wire logic                          capture_i,
  input  wire logic                          step_i,
  input  wire logic                          emit_i,
  input  wire jss_pkg::uword_t               uword_i,
  output jss_pkg::dp_status_t                status_o,
  output logic                               tms_o,
  output logic                               tdi_o,
  output logic [jss_pkg::DataW-1:0]          captured_o
);

  localparam logic [jss_pkg::CntW-1:0] CntMax = jss_pkg::CntW'(MAX_SCAN_BITS);

  logic [jss_pkg::CntW-1:0]  cnt_q, cnt_d, n_cap;
  logic [jss_pkg::DataW-1:0] data_q, data_d;
  logic [jss_pkg::DataW-1:0] capt_q, capt_d;
  logic                      idle_q, idle_d;
  logic                      level_q, level_d;
  logic [63:0]               mask_wide;
  logic                      shift;

  assign n_cap     = (bit_count_i > CntMax) ? CntMax : bit_count_i;
  assign mask_wide = (64'd1 << n_cap) - 64'd1;

  assign status_o.cnt_zero = (cnt_q == '0);
  assign status_o.cnt_gt1  = (cnt_q > jss_pkg::CntW'(1));

  assign shift = step_i && (uword_i.seq == jss_pkg::SEQ_LOOP) && status_o.cnt_gt1;

  always_comb begin
    case (uword_i.tdi_sel)
      jss_pkg::TDI_DATA: tdi_o = data_q[0];
      jss_pkg::TDI_ZERO: tdi_o = 1'b0;
      default:           tdi_o = level_q;
    endcase
    case (uword_i.tms_sel)
      jss_pkg::TMS_SET:   tms_o = 1'b1;
      jss_pkg::TMS_NIDLE: tms_o = ~idle_q;
      default:            tms_o = 1'b0;
    endcase
    captured_o = uword_i.cap_out ? capt_q : '0;
  end

  always_comb begin
    cnt_d   = cnt_q;
    data_d  = data_q;
    capt_d  = capt_q;
    idle_d  = idle_q;
    level_d = level_q;
    if (load_i) begin
      // ir with a zero count still shifts one bit
      if ((req_type_i == jss_pkg::REQ_IR) && (n_cap == '0)) begin
        cnt_d = jss_pkg::CntW'(1);
      end else begin
        cnt_d = n_cap;
      end
      data_d = scan_data_i;
      capt_d = capture_i ? (tdo_pattern_i & mask_wide[jss_pkg::DataW-1:0]) : '0;
      idle_d = end_in_idle_i;
    end else begin
      if (shift) begin
        cnt_d  = cnt_q - jss_pkg::CntW'(1);
        data_d = {1'b0, data_q[jss_pkg::DataW-1:1]};
      end
      if (emit_i && uword_i.wr_level) begin
        level_d = tdi_o;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q   <= '0;
      level_q <= 1'b0;
    end else begin
      cnt_q   <= cnt_d;
      level_q <= level_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
    capt_q <= capt_d;
    idle_q <= idle_d;
  end

endmodule

`default_nettype wire

// ===== hdl/jtag_scan_sequencer.sv =====
// ----------------------------------------------------------------------------
// jtag_scan_sequencer
// Microcoded JTAG TAP master: turns one scan command into a stream of
// TCK pulse descriptors with their TMS and TDI levels.
// ----------------------------------------------------------------------------
// usage:
//   s_axis carries one command per transfer; tuser is the request type
//   (tap reset, ir shift, dr transfer), an unused type is dropped silently.
//   m_axis gives one transfer per tck pulse, tlast on the final one of a
//   command; a dr transfer puts its captured tdo word on that final one.
//   the program counter steps the control store once per cycle unless
//   stalled; each step that emits loads the output register, and bit
//   shifting stays on one loop step while the bit counter runs down.
//   a tap reset gives 6 results, an ir shift n+5 (6 for a zero count),
//   a dr transfer n+4 (one result for a zero count), n capped at
//   MAX_SCAN_BITS, at most 61. a command occupies its transfer cycle
//   plus one step per result, one more step for the bit loop exit (ir,
//   dr) and one for the zero-count branch test (dr). the first result
//   shows once the first emitting step loads the output register.
//   a new command is taken as soon as the last result is in the output
//   register, while it still waits for the receiver.
//   a stalled receiver freezes the program counter; nothing is lost.
//   reset clears the sequencer and the stored tdi level to low.
// ----------------------------------------------------------------------------
`default_nettype none

module jtag_scan_sequencer #(
  parameter int unsigned MAX_SCAN_BITS = 56
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  // bit_count[5:0], scan_data[61:6], tdo_pattern[117:62], end_in_idle[118],
  // capture[119]
  input  wire logic [119:0] s_axis_tdata,
  // req_type[1:0]
  input  wire logic [1:0]   s_axis_tuser,
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // tck_pulse[0], tms[1], tdi[2], captured_data[58:3], zero[63:59]
  output logic [63:0]       m_axis_tdata,
  output logic              m_axis_tlast
);

  logic                          busy_q, busy_d;
  logic [jss_pkg::PcW-1:0]       pc_q, pc_d;
  logic                          out_valid_q, out_valid_d;
  logic                          out_tck_q, out_tms_q, out_tdi_q, out_last_q;
  logic [jss_pkg::DataW-1:0]     out_capt_q;
  jss_pkg::uword_t               uword;
  jss_pkg::dp_status_t           status;
  logic                          accept, step, emit;
  logic                          dp_tms, dp_tdi;
  logic [jss_pkg::DataW-1:0]     dp_capt;
  jss_pkg::req_e                 req;

  assign req           = jss_pkg::req_e'(s_axis_tuser);
  assign s_axis_tready = ~busy_q;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign step          = busy_q && (!out_valid_q || m_axis_tready);
  // a loop step at its last bit falls through without a result
  assign emit          = step && uword.emit &&
                         !((uword.seq == jss_pkg::SEQ_LOOP) && !status.cnt_gt1);

  jss_ucode_rom u_rom (
    .pc_i    (pc_q),
    .uword_o (uword)
  );

  jss_datapath #(
    .MAX_SCAN_BITS (MAX_SCAN_BITS)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .load_i        (accept),
    .req_type_i    (s_axis_tuser),
    .bit_count_i   (s_axis_tdata[5:0]),
    .scan_data_i   (s_axis_tdata[61:6]),
    .tdo_pattern_i (s_axis_tdata[117:62]),
    .end_in_idle_i (s_axis_tdata[118]),
    .capture_i     (s_axis_tdata[119]),
    .step_i        (step),
    .emit_i        (emit),
    .uword_i       (uword),
    .status_o      (status),
    .tms_o         (dp_tms),
    .tdi_o         (dp_tdi),
    .captured_o    (dp_capt)
  );

  always_comb begin
    busy_d = busy_q;
    pc_d   = pc_q;
    if (accept) begin
      unique case (req)
        jss_pkg::REQ_RESET: begin
          busy_d = 1'b1;
          pc_d   = jss_pkg::AddrReset;
        end
        jss_pkg::REQ_IR: begin
          busy_d = 1'b1;
          pc_d   = jss_pkg::AddrIr;
        end
        jss_pkg::REQ_DR: begin
          busy_d = 1'b1;
          pc_d   = jss_pkg::AddrDr;
        end
        default: begin
          busy_d = 1'b0;
        end
      endcase
    end else if (step) begin
      unique case (uword.seq)
        jss_pkg::SEQ_LOOP: begin
          if (!status.cnt_gt1) begin
            pc_d = pc_q + jss_pkg::PcW'(1);
          end
        end
        jss_pkg::SEQ_JZ: begin
          pc_d = status.cnt_zero ? uword.target : pc_q + jss_pkg::PcW'(1);
        end
        jss_pkg::SEQ_END: begin
          busy_d = 1'b0;
        end
        default: begin
          pc_d = pc_q + jss_pkg::PcW'(1);
        end
      endcase
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (emit) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      pc_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      pc_q        <= pc_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_tck_q  <= uword.tck;
      out_tms_q  <= dp_tms;
      out_tdi_q  <= dp_tdi;
      out_last_q <= (uword.seq == jss_pkg::SEQ_END);
      out_capt_q <= dp_capt;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tdata  = {5'd0, out_capt_q, out_tdi_q, out_tms_q, out_tck_q};

  // captured word only ever rides on the final transfer of a command
  a_capt_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tlast) |-> (m_axis_tdata[58:3] == '0))
    else $error("captured data outside the last transfer");

  // a non-pulse result only closes a zero-length dr transfer
  a_nopulse_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tdata[0]) |-> m_axis_tlast)
    else $error("non-pulse result that is not last");

  a_pc_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (pc_q <= jss_pkg::AddrLast))
    else $error("program counter outside the control store");

  a_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(busy_q) |-> $past(s_axis_tvalid && s_axis_tready))
    else $error("sequencer started without a command transfer");

endmodule

`default_nettype wire
